// File: src/hse_pkg.sv
// Package for the heap sort engine: sizes, beat types, memory port request and states.
// Used by hse_store, hse_seq and heap_sort_engine; depends on nothing.
package hse_pkg;

    localparam int CAPACITY = 32;
    localparam int C_AW     = $clog2(CAPACITY);
    localparam int C_CW     = $clog2(CAPACITY + 1);

    typedef logic [C_AW-1:0] t_addr;
    typedef logic [C_CW-1:0] t_count;

    typedef struct packed {
        logic signed [31:0] value;
        logic               is_last;
    } t_in_beat;

    typedef struct packed {
        logic signed [31:0] sorted_value;
        logic               is_last_out;
        logic               overflowed;
    } t_out_beat;

    typedef struct packed {
        logic               we;
        t_addr              waddr;
        logic signed [31:0] wdata;
        t_addr              raddr;
    } t_mem_req;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_ROOT,
        ST_VAL,
        ST_CHILD,
        ST_LC,
        ST_RC,
        ST_CMP,
        ST_NEXT,
        ST_XR0,
        ST_XRK,
        ST_XW,
        ST_ERD,
        ST_EOUT,
        ST_EWAIT
    } t_state;

endpackage

// File: src/hse_store.sv
// Element storage of the heap sort engine: one write port, one registered read port.
// Depends on hse_pkg.
module hse_store (
    input  logic                     i_clk,
    input  hse_pkg::t_mem_req        i_req,
    output logic signed [31:0]       o_rdata
);

    logic signed [31:0] r_mem [hse_pkg::CAPACITY];
    logic signed [31:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/hse_cmp.sv
// Shared signed comparator of the heap sort engine.
// Depends on nothing.
module hse_cmp (
    input  logic signed [31:0] i_a,
    input  logic signed [31:0] i_b,
    output logic               o_gt
);

    assign o_gt = (i_a > i_b);

endmodule

// File: src/hse_seq.sv
// Sequencer of the heap sort engine: loads a set, runs heap build and extraction
// through the shared comparator and the store, and emits the sorted beats. Depends on hse_pkg.
module hse_seq (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  hse_pkg::t_in_beat     i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output hse_pkg::t_out_beat    o_out_data,
    output hse_pkg::t_mem_req     o_req,
    input  logic signed [31:0]    i_rdata,
    output logic signed [31:0]    o_cmp_a,
    output logic signed [31:0]    o_cmp_b,
    input  logic                  i_cmp_gt
);

    hse_pkg::t_state    r_state, n_state;
    hse_pkg::t_count    r_count, n_count;
    logic               r_ovf, n_ovf;
    logic               r_build, n_build;
    hse_pkg::t_addr     r_k, n_k;
    hse_pkg::t_count    r_size, n_size;
    hse_pkg::t_addr     r_pos, n_pos;
    hse_pkg::t_addr     r_big, n_big;
    hse_pkg::t_addr     r_idx, n_idx;
    logic signed [31:0] r_val, n_val;
    logic signed [31:0] r_cl, n_cl;
    hse_pkg::t_out_beat r_out, n_out;
    logic               r_out_valid, n_out_valid;

    logic                      w_acc;
    logic                      w_room;
    hse_pkg::t_count           w_cnt_new;
    hse_pkg::t_count           w_parent;
    logic [hse_pkg::C_CW:0]    w_lc;
    logic [hse_pkg::C_CW:0]    w_rc;
    logic                      w_lc_in;
    logic                      w_rc_in;
    logic                      w_out_acc;
    logic                      w_idx_last;

    assign o_in_ready  = (r_state == hse_pkg::ST_LOAD);
    assign w_acc       = i_in_valid && o_in_ready;
    assign w_room      = (r_count < hse_pkg::C_CW'(hse_pkg::CAPACITY));
    assign w_cnt_new   = w_room ? (r_count + hse_pkg::C_CW'(1)) : r_count;
    assign w_parent    = (w_cnt_new - hse_pkg::C_CW'(2)) >> 1;
    assign w_lc        = (hse_pkg::C_CW+1)'({r_pos, 1'b1});
    assign w_rc        = w_lc + (hse_pkg::C_CW+1)'(1);
    assign w_lc_in     = (w_lc < {1'b0, r_size});
    assign w_rc_in     = (w_rc < {1'b0, r_size});
    assign w_out_acc   = r_out_valid && i_out_ready;
    assign w_idx_last  = (r_idx == hse_pkg::C_AW'(r_count - hse_pkg::C_CW'(1)));
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        o_cmp_a = r_cl;
        o_cmp_b = r_val;
        if (r_state == hse_pkg::ST_RC) begin
            o_cmp_a = i_rdata;
            o_cmp_b = r_cl;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            hse_pkg::ST_LOAD: begin
                if (w_acc && i_in_data.is_last) begin
                    n_state = (w_cnt_new >= hse_pkg::C_CW'(2)) ? hse_pkg::ST_ROOT
                                                                 : hse_pkg::ST_ERD;
                end
            end
            hse_pkg::ST_ROOT:  n_state = hse_pkg::ST_VAL;
            hse_pkg::ST_VAL:   n_state = hse_pkg::ST_CHILD;
            hse_pkg::ST_CHILD: n_state = w_lc_in ? hse_pkg::ST_LC : hse_pkg::ST_NEXT;
            hse_pkg::ST_LC:    n_state = w_rc_in ? hse_pkg::ST_RC : hse_pkg::ST_CMP;
            hse_pkg::ST_RC:    n_state = hse_pkg::ST_CMP;
            hse_pkg::ST_CMP:   n_state = i_cmp_gt ? hse_pkg::ST_CHILD : hse_pkg::ST_NEXT;
            hse_pkg::ST_NEXT: begin
                if (r_build) begin
                    n_state = (r_k == '0) ? hse_pkg::ST_XR0 : hse_pkg::ST_ROOT;
                end else begin
                    n_state = (r_k == hse_pkg::C_AW'(1)) ? hse_pkg::ST_ERD : hse_pkg::ST_XR0;
                end
            end
            hse_pkg::ST_XR0:   n_state = hse_pkg::ST_XRK;
            hse_pkg::ST_XRK:   n_state = hse_pkg::ST_XW;
            hse_pkg::ST_XW:    n_state = hse_pkg::ST_CHILD;
            hse_pkg::ST_ERD:   n_state = hse_pkg::ST_EOUT;
            hse_pkg::ST_EOUT:  n_state = hse_pkg::ST_EWAIT;
            hse_pkg::ST_EWAIT: begin
                if (w_out_acc) begin
                    n_state = w_idx_last ? hse_pkg::ST_LOAD : hse_pkg::ST_ERD;
                end
            end
            default:           n_state = hse_pkg::ST_LOAD;
        endcase
    end

    always_comb begin
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_build     = r_build;
        n_k         = r_k;
        n_size      = r_size;
        n_pos       = r_pos;
        n_big       = r_big;
        n_idx       = r_idx;
        n_val       = r_val;
        n_cl        = r_cl;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        o_req       = '0;
        unique case (r_state)
            hse_pkg::ST_LOAD: begin
                if (w_acc) begin
                    if (w_room) begin
                        o_req.we    = 1'b1;
                        o_req.waddr = hse_pkg::C_AW'(r_count);
                        o_req.wdata = i_in_data.value;
                    end else begin
                        n_ovf = 1'b1;
                    end
                    n_count = w_cnt_new;
                    if (i_in_data.is_last) begin
                        n_build = 1'b1;
                        n_size  = w_cnt_new;
                        n_k     = hse_pkg::C_AW'(w_parent);
                        n_pos   = hse_pkg::C_AW'(w_parent);
                        n_idx   = '0;
                    end
                end
            end
            hse_pkg::ST_ROOT: begin
                o_req.raddr = r_pos;
            end
            hse_pkg::ST_VAL: begin
                n_val = i_rdata;
            end
            hse_pkg::ST_CHILD: begin
                if (w_lc_in) begin
                    o_req.raddr = hse_pkg::C_AW'(w_lc);
                end else begin
                    o_req.we    = 1'b1;
                    o_req.waddr = r_pos;
                    o_req.wdata = r_val;
                end
            end
            hse_pkg::ST_LC: begin
                n_cl  = i_rdata;
                n_big = hse_pkg::C_AW'(w_lc);
                if (w_rc_in) begin
                    o_req.raddr = hse_pkg::C_AW'(w_rc);
                end
            end
            hse_pkg::ST_RC: begin
                if (i_cmp_gt) begin
                    n_cl  = i_rdata;
                    n_big = hse_pkg::C_AW'(w_rc);
                end
            end
            hse_pkg::ST_CMP: begin
                o_req.we    = 1'b1;
                o_req.waddr = r_pos;
                if (i_cmp_gt) begin
                    o_req.wdata = r_cl;
                    n_pos       = r_big;
                end else begin
                    o_req.wdata = r_val;
                end
            end
            hse_pkg::ST_NEXT: begin
                if (r_build) begin
                    if (r_k == '0) begin
                        n_build = 1'b0;
                        n_k     = hse_pkg::C_AW'(r_size - hse_pkg::C_CW'(1));
                    end else begin
                        n_k   = r_k - hse_pkg::C_AW'(1);
                        n_pos = r_k - hse_pkg::C_AW'(1);
                    end
                end else begin
                    if (r_k == hse_pkg::C_AW'(1)) begin
                        n_idx = '0;
                    end else begin
                        n_k = r_k - hse_pkg::C_AW'(1);
                    end
                end
            end
            hse_pkg::ST_XR0: begin
                o_req.raddr = '0;
            end
            hse_pkg::ST_XRK: begin
                n_cl        = i_rdata;
                o_req.raddr = r_k;
            end
            hse_pkg::ST_XW: begin
                n_val       = i_rdata;
                o_req.we    = 1'b1;
                o_req.waddr = r_k;
                o_req.wdata = r_cl;
                n_size      = hse_pkg::C_CW'(r_k);
                n_pos       = '0;
            end
            hse_pkg::ST_ERD: begin
                o_req.raddr = r_idx;
            end
            hse_pkg::ST_EOUT: begin
                n_out.sorted_value = i_rdata;
                n_out.is_last_out  = w_idx_last;
                n_out.overflowed   = r_ovf;
                n_out_valid        = 1'b1;
            end
            hse_pkg::ST_EWAIT: begin
                if (w_out_acc) begin
                    n_out_valid = 1'b0;
                    if (w_idx_last) begin
                        n_count = '0;
                        n_ovf   = 1'b0;
                    end else begin
                        n_idx = r_idx + hse_pkg::C_AW'(1);
                    end
                end
            end
            default: begin
                o_req = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hse_pkg::ST_LOAD;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_build     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_build     <= n_build;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k    <= n_k;
        r_size <= n_size;
        r_pos  <= n_pos;
        r_big  <= n_big;
        r_idx  <= n_idx;
        r_val  <= n_val;
        r_cl   <= n_cl;
        r_out  <= n_out;
    end

endmodule

// File: src/heap_sort_engine.sv
// Top level of the heap sort engine: sequencer, element store and shared comparator.
// Depends on hse_pkg, hse_store, hse_cmp and hse_seq.
//
//   Channel   Direction  Handshake                 Beat type
//   in        input      i_in_valid / o_in_ready   hse_pkg::t_in_beat
//   out       output     o_out_valid / i_out_ready hse_pkg::t_out_beat
//
// Loading accepts one input beat per cycle. After the beat marked last, each sift level reads
// the left child, and the right child if there is one, through the single store read port, then
// compares and writes back; each sorted beat is then read, registered and held until accepted.
// No input beat is taken from the last input beat until the last output beat is accepted.
// Reset is synchronous and active low; it empties the set and clears the overflow flag.
module heap_sort_engine (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  hse_pkg::t_in_beat  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output hse_pkg::t_out_beat o_out_data
);

    hse_pkg::t_mem_req  w_req;
    logic signed [31:0] w_rdata;
    logic signed [31:0] w_cmp_a;
    logic signed [31:0] w_cmp_b;
    logic               w_cmp_gt;

    hse_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .o_req       (w_req),
        .i_rdata     (w_rdata),
        .o_cmp_a     (w_cmp_a),
        .o_cmp_b     (w_cmp_b),
        .i_cmp_gt    (w_cmp_gt)
    );

    hse_store u_store (
        .i_clk   (i_clk),
        .i_req   (w_req),
        .o_rdata (w_rdata)
    );

    hse_cmp u_cmp (
        .i_a  (w_cmp_a),
        .i_b  (w_cmp_b),
        .o_gt (w_cmp_gt)
    );

endmodule
